>>> hw/rtl/channel_hop_capture_log_unit_defines.svh
// Assertion macros shared by the channel hop capture log RTL.
`ifndef CHANNEL_HOP_CAPTURE_LOG_UNIT_DEFINES_SVH
`define CHANNEL_HOP_CAPTURE_LOG_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is held low.
`define CHL_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("channel hop capture log: assertion failed");
// Clocked check that also holds through reset.
`define CHL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("channel hop capture log: assertion failed");
`else
`define CHL_ASSERT(lbl, clk, rstn, prop)
`define CHL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/chlog_pkg.sv
// Types and constants shared by the channel hop capture log modules.
`timescale 1ns / 1ps

package chlog_pkg;

    // Operation codes of an input item
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PACKET = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [3:0] REG_HOP_DWELL       = 4'd0;
    localparam logic [3:0] REG_PRESS_HOLDOFF   = 4'd1;
    localparam logic [3:0] REG_LOWEST_CHANNEL  = 4'd2;
    localparam logic [3:0] REG_HIGHEST_CHANNEL = 4'd3;

    // Configuration reset values
    localparam logic [15:0] HOP_DWELL_AT_RESET     = 16'd200;
    localparam logic [15:0] PRESS_HOLDOFF_AT_RESET = 16'd180;
    localparam logic [6:0]  LOWEST_AT_RESET        = 7'd2;
    localparam logic [6:0]  HIGHEST_AT_RESET       = 7'd125;

    localparam logic [6:0]  CHANNEL_TOP      = 7'd125;
    localparam logic [6:0]  CHANNEL_AT_RESET = 7'd76;
    localparam logic [15:0] AGE_MAX          = 16'hFFFF;
    localparam logic [63:0] PAYLOAD_ZERO     = 64'h0000_0000_0000_0000;
    localparam logic [63:0] PAYLOAD_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // One log row: channel tag and payload
    typedef struct packed {
        logic [6:0]  channel;
        logic [63:0] payload;
    } row_t;

    // Per-cell control from the log sequencer
    typedef struct packed {
        logic take_new;
        logic shift;
        logic read_sel;
    } cell_ctrl_t;

    // One result item
    typedef struct packed {
        logic [6:0]  channel;
        logic        hop_enabled;
        logic        retune;
        logic        accepted;
        logic [31:0] total_captured;
        logic [4:0]  rows_held;
        logic [6:0]  row_channel;
        logic [63:0] row_payload;
    } res_t;

endpackage

>>> hw/rtl/channel_hop_capture_log_unit.sv
// Top level: channel sequencer, debounce, packet filter and capture log chain.
// Each result item is registered in the output register, or in the skid while it is held.
// Throughput: one item per cycle; input stalls only while the result register and skid are full.
// The log is a chain of row cells that moves down one row on each append when full.
// Reset returns channel, hop, debounce, ages, row count, total and config to reset values.
// Log rows are not cleared; only rows below the row count are ever read.
`timescale 1ns / 1ps
`include "channel_hop_capture_log_unit_defines.svh"

module channel_hop_capture_log_unit import chlog_pkg::*; #(
    parameter int LOG_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic        s_left_pressed,
    input  logic        s_right_pressed,
    input  logic        s_up_pressed,
    input  logic [63:0] s_payload,
    input  logic [3:0]  s_row_index,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_channel,
    output logic        m_hop_enabled,
    output logic        m_retune,
    output logic        m_accepted,
    output logic [31:0] m_total_captured,
    output logic [4:0]  m_rows_held,
    output logic [6:0]  m_row_channel,
    output logic [63:0] m_row_payload,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(LOG_DEPTH);

    // configuration
    logic [15:0] hop_dwell_reg;
    logic [15:0] press_holdoff_reg;
    logic [6:0]  lowest_reg;
    logic [6:0]  highest_reg;

    // sequencer state
    logic [6:0]       channel_reg, channel_next;
    logic             hop_reg, hop_next;
    logic             awaiting_reg, awaiting_next;
    logic [15:0]      press_age_reg, press_age_next;
    logic [15:0]      dwell_age_reg, dwell_age_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      total_reg, total_next;

    logic        push;
    logic        res_ready;
    op_t         op;
    logic [6:0]  lo_lim;
    logic [6:0]  hi_lim;
    logic [15:0] press_inc;
    logic [15:0] dwell_inc;
    logic [6:0]  press_channel;
    logic        any_button;
    logic        plausible;
    logic        append;
    logic        log_full;
    row_t        new_row;
    row_t        read_row;
    res_t        res;

    cell_ctrl_t  ctrl_w [LOG_DEPTH];
    row_t        row_w  [LOG_DEPTH];
    row_t        rd_w   [LOG_DEPTH+1];

    function automatic logic [6:0] step_up(input logic [6:0] ch, input logic [6:0] lo,
                                           input logic [6:0] hi);
        step_up = (ch >= hi || ch < lo) ? lo : ch + 7'd1;
    endfunction

    function automatic logic [6:0] step_down(input logic [6:0] ch, input logic [6:0] lo,
                                             input logic [6:0] hi);
        step_down = (ch <= lo || ch > hi) ? hi : ch - 7'd1;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = res_ready;
    assign push      = s_valid && s_ready;
    assign op        = op_t'(s_operation);

    // Write configuration registers; ignore indexes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_dwell_reg     <= HOP_DWELL_AT_RESET;
            press_holdoff_reg <= PRESS_HOLDOFF_AT_RESET;
            lowest_reg        <= LOWEST_AT_RESET;
            highest_reg       <= HIGHEST_AT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HOP_DWELL:       hop_dwell_reg     <= cfg_data;
                REG_PRESS_HOLDOFF:   press_holdoff_reg <= cfg_data;
                REG_LOWEST_CHANNEL:  lowest_reg        <= cfg_data[6:0];
                REG_HIGHEST_CHANNEL: highest_reg       <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Clamp channel limits and pre-compute shared terms
    assign lo_lim     = (lowest_reg  > CHANNEL_TOP) ? CHANNEL_TOP : lowest_reg;
    assign hi_lim     = (highest_reg > CHANNEL_TOP) ? CHANNEL_TOP : highest_reg;
    assign press_inc  = (press_age_reg == AGE_MAX) ? AGE_MAX : press_age_reg + 16'd1;
    assign dwell_inc  = (dwell_age_reg == AGE_MAX) ? AGE_MAX : dwell_age_reg + 16'd1;
    assign any_button = s_left_pressed || s_right_pressed || s_up_pressed;
    assign plausible  = (s_payload != PAYLOAD_ZERO) && (s_payload != PAYLOAD_ONES);
    assign log_full   = (count_reg == COUNT_FULL);
    assign append     = (op == OP_PACKET) && plausible;
    assign new_row    = '{channel: channel_reg, payload: s_payload};

    // Next state for one item
    always_comb begin
        channel_next   = channel_reg;
        hop_next       = hop_reg;
        awaiting_next  = awaiting_reg;
        press_age_next = press_age_reg;
        dwell_age_next = dwell_age_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        press_channel  = channel_reg;
        unique case (op)
            OP_TICK: begin
                press_age_next = press_inc;
                dwell_age_next = dwell_inc;
                if (awaiting_reg) begin
                    if (!any_button) begin
                        awaiting_next = 1'b0;
                    end
                end else if (any_button && press_inc > press_holdoff_reg) begin
                    if (s_up_pressed) begin
                        hop_next = !hop_reg;
                    end else if (s_right_pressed) begin
                        press_channel = step_up(channel_reg, lo_lim, hi_lim);
                    end else begin
                        press_channel = step_down(channel_reg, lo_lim, hi_lim);
                    end
                    press_age_next = 16'd0;
                    awaiting_next  = 1'b1;
                end
                channel_next = press_channel;
                // automatic hop after the dwell
                if (hop_next && dwell_inc >= hop_dwell_reg) begin
                    channel_next   = step_up(press_channel, lo_lim, hi_lim);
                    dwell_age_next = 16'd0;
                end
            end
            OP_PACKET: begin
                if (plausible) begin
                    count_next = log_full ? count_reg : count_reg + CNT_W'(1);
                    total_next = total_reg + 32'd1;
                end
            end
            OP_READ: ;
            default: ;
        endcase
    end

    // Advance sequencer state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg   <= CHANNEL_AT_RESET;
            hop_reg       <= 1'b1;
            awaiting_reg  <= 1'b1;
            press_age_reg <= 16'd0;
            dwell_age_reg <= 16'd0;
            count_reg     <= '0;
            total_reg     <= 32'd0;
        end else if (push) begin
            channel_reg   <= channel_next;
            hop_reg       <= hop_next;
            awaiting_reg  <= awaiting_next;
            press_age_reg <= press_age_next;
            dwell_age_reg <= dwell_age_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
        end
    end

    // Log chain: append at the fill point, or move down and append at the end when full
    assign rd_w[LOG_DEPTH] = '0;

    for (genvar k = 0; k < LOG_DEPTH; k++) begin : g_cell
        assign ctrl_w[k].take_new = push && append &&
            (log_full ? (k == LOG_DEPTH - 1) : (count_reg == CNT_W'(k)));
        assign ctrl_w[k].shift    = push && append && log_full;
        assign ctrl_w[k].read_sel = (op == OP_READ) && (32'(s_row_index) == 32'(k)) &&
                                    (CNT_W'(k) < count_reg);

        chlog_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl_w[k]),
            .new_row (new_row),
            .up_row  ((k == LOG_DEPTH - 1) ? new_row : row_w[(k + 1) % LOG_DEPTH]),
            .rd_in   (rd_w[k+1]),
            .row_out (row_w[k]),
            .rd_out  (rd_w[k])
        );
    end

    assign read_row = rd_w[0];

    // Build the result item
    always_comb begin
        res.channel        = channel_next;
        res.hop_enabled    = hop_next;
        res.retune         = (channel_next != channel_reg);
        res.accepted       = append;
        res.total_captured = total_next;
        res.rows_held      = 5'(count_next);
        res.row_channel    = read_row.channel;
        res.row_payload    = read_row.payload;
    end

    chlog_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   ({m_channel, m_hop_enabled, m_retune, m_accepted, m_total_captured,
                     m_rows_held, m_row_channel, m_row_payload})
    );

    `CHL_ASSERT(a_count_bound, aclk, aresetn, count_reg <= COUNT_FULL)
    `CHL_ASSERT(a_channel_bound, aclk, aresetn, channel_reg <= CHANNEL_TOP)
    `CHL_ASSERT(a_reject_keeps_total, aclk, aresetn, (push && op == OP_PACKET && !plausible) |=> $stable(total_reg))
    `CHL_ASSERT(a_full_stays_full, aclk, aresetn, (push && append && log_full) |=> (count_reg == COUNT_FULL))

endmodule

>>> hw/rtl/chlog_cell.sv
// One row cell of the capture log chain.
`timescale 1ns / 1ps

module chlog_cell import chlog_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  row_t       new_row,
    input  row_t       up_row,
    input  row_t       rd_in,
    output row_t       row_out,
    output row_t       rd_out
);

    row_t row_reg;

    // Load the new row, or take the neighbour's row when the log moves down
    always_ff @(posedge aclk) begin
        if (ctrl.take_new) begin
            row_reg <= new_row;
        end else if (ctrl.shift) begin
            row_reg <= up_row;
        end
    end

    assign row_out = row_reg;

    // Merge this row into the read chain when selected
    assign rd_out = ctrl.read_sel ? (rd_in | row_reg) : rd_in;

endmodule

>>> hw/rtl/chlog_skid.sv
// Output register with skid stage for result items.
`timescale 1ns / 1ps
`include "channel_hop_capture_log_unit_defines.svh"

module chlog_skid import chlog_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Control: refill the output from the skid first, else from the new item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: same steering, no reset
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (push) begin
                out_res_reg <= in_res;
            end
        end else if (push) begin
            skid_res_reg <= in_res;
        end
    end

    `CHL_ASSERT(a_skid_needs_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `CHL_ASSERT(a_skid_holds, aclk, aresetn, (skid_valid_reg && !out_ready) |=> skid_valid_reg)
    `CHL_ASSERT(a_out_holds, aclk, aresetn, (out_valid_reg && !out_ready) |=> out_valid_reg)

endmodule
